>>> hdl/r2e_pkg.sv
// Shared types, widths and constants of the rotation-to-Euler-angles unit.
// No dependencies; every other file of the unit except the channel interfaces imports this package.
`default_nettype none
package r2e_pkg;

	// Default number of CORDIC micro-rotations and the size of the arctangent table.
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	// Operand width at the CORDIC inputs, datapath width and angle accumulator width.
	localparam int OPW = 21;
	localparam int DW  = 34;
	localparam int ZW  = 35;

	// Integer square root: 37-bit radicand, one root bit per stage.
	localparam int SQ_NW     = 37;
	localparam int SQ_RW     = 38;
	localparam int SQ_STAGES = 19;

	// Angles in Q2.13 and the accumulator constant pi in Q.30.
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [15:0] PI_Q13      = 16'sd25736;
	localparam logic signed [ZW-1:0] PI_Q30    = 35'sd3373259426;

	// atan(2^-i) scaled by 2^30, rounded to nearest.
	localparam logic [29:0] ATAN_TAB [0:ATAN_LEN-1] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	// Operands that wait beside the square root for the three arctangents.
	typedef struct packed {
		logic signed [OPW-1:0] bank_y;
		logic signed [OPW-1:0] bank_x;
		logic signed [OPW-1:0] head_y;
		logic signed [OPW-1:0] head_x;
		logic signed [OPW-1:0] asin_y;
		pole_t                 pole;
	} r2e_side_t;

endpackage
`default_nettype wire

>>> hdl/r2e_if.sv
// Valid/ready channel interfaces of the rotation-to-Euler-angles unit.
// Depends on nothing; payload widths follow the unit's field definitions.
`default_nettype none
interface r2e_mat_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] r00;
	logic signed [15:0] r02;
	logic signed [15:0] r10;
	logic signed [15:0] r11;
	logic signed [15:0] r12;
	logic signed [15:0] r20;
	logic signed [15:0] r22;
	modport source (output valid, r00, r02, r10, r11, r12, r20, r22, input ready);
	modport sink   (input valid, r00, r02, r10, r11, r12, r20, r22, output ready);
endinterface

interface r2e_ang_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] bank_angle;
	logic signed [14:0] attitude_angle;
	logic signed [15:0] heading_angle;
	logic [1:0]         pole_case;
	modport source (output valid, bank_angle, attitude_angle, heading_angle, pole_case,
		input ready);
	modport sink   (input valid, bank_angle, attitude_angle, heading_angle, pole_case,
		output ready);
endinterface

interface r2e_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hdl/rotation_to_euler_angles_unit.sv
// Throughput: one matrix per clock; the whole pipeline advances whenever the output
// register is empty or its beat is taken, so a stall only freezes stages in place.
// Reset clears all valid bits and loads the pole threshold with 16351 (0.998 in Q1.14).
// Depends on r2e_pkg, the channel interfaces, r2e_isqrt and r2e_cordic.
`default_nettype none
module rotation_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = r2e_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	r2e_mat_if.sink    mat,
	r2e_ang_if.source  ang,
	r2e_cfg_if.sink    cfg
);
	import r2e_pkg::*;

	// The arctangent pipeline depth: input turn, the rotations, and the rounding stage.
	localparam int NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
	localparam int CL  = NST + 2;
	localparam int VL  = SQ_STAGES + CL;

	logic [14:0] thr_q;
	logic        adv;

	// Stage 1 holds the accepted beat as it arrived.
	logic               valid_s1;
	logic signed [15:0] r00_s1, r02_s1, r10_s1, r11_s1, r12_s1, r20_s1, r22_s1;

	// Stage 2 holds the pole decision, the arctangent operands and the square of sin.
	logic               valid_s2;
	r2e_side_t          side_s2;
	logic [28:0]        sq_s2;

	logic signed [16:0] r10_e, thr_e;
	logic signed [15:0] s_sat;
	logic signed [31:0] s_prod;
	r2e_side_t          side_c;
	logic [28:0]        rem;

	logic [SQ_STAGES-1:0] root;
	r2e_side_t            side_d [0:SQ_STAGES-1];
	logic                 vld_d  [0:VL-1];
	pole_t                pole_d [0:VL-1];

	logic signed [15:0] bank_a, asin_a, head_a;

	logic               out_valid_q;
	logic signed [15:0] bank_q;
	logic signed [14:0] att_q;
	logic signed [15:0] head_q;
	pole_t              pole_q;

	// Every stage moves together; the output register is the only place a beat can wait.
	assign adv       = !out_valid_q || ang.ready;
	assign mat.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd16351;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= mat.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r00_s1 <= mat.r00;
			r02_s1 <= mat.r02;
			r10_s1 <= mat.r10;
			r11_s1 <= mat.r11;
			r12_s1 <= mat.r12;
			r20_s1 <= mat.r20;
			r22_s1 <= mat.r22;
		end
	end

	// The pole test compares the signed entry against the unsigned threshold in 17 bits.
	// In the regular case sin is clamped to the unit range before the square root.
	assign r10_e = 17'(r10_s1);
	assign thr_e = signed'({2'b00, thr_q});

	always_comb begin
		if (r10_s1 > 16'sd16384)
			s_sat = 16'sd16384;
		else if (r10_s1 < -16'sd16384)
			s_sat = -16'sd16384;
		else
			s_sat = r10_s1;

		side_c.bank_y = -OPW'(r12_s1);
		side_c.bank_x = OPW'(r11_s1);
		side_c.asin_y = OPW'(s_sat) <<< 4;
		if (r10_e > thr_e) begin
			side_c.pole   = POLE_NORTH;
			side_c.head_y = OPW'(r02_s1);
			side_c.head_x = OPW'(r22_s1);
		end else if (r10_e < -thr_e) begin
			side_c.pole   = POLE_SOUTH;
			side_c.head_y = OPW'(r02_s1);
			side_c.head_x = OPW'(r22_s1);
		end else begin
			side_c.pole   = POLE_NONE;
			side_c.head_y = -OPW'(r20_s1);
			side_c.head_x = OPW'(r00_s1);
		end
	end

	assign s_prod = s_sat * s_sat;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
			sq_s2   <= s_prod[28:0];
		end
	end

	// cos is the floor square root of (1 - sin^2) scaled to Q.18.
	assign rem = 29'h1000_0000 - sq_s2;

	r2e_isqrt u_isqrt (
		.clk      (clk),
		.adv      (adv),
		.radicand ({rem, 8'h00}),
		.root     (root)
	);

	// Operands and control ride alongside the square root and the arctangents.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s2;
			for (int k = 1; k < SQ_STAGES; k++)
				side_d[k] <= side_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VL; k++)
				vld_d[k] <= 1'b0;
		end else if (adv) begin
			vld_d[0] <= valid_s2;
			for (int k = 1; k < VL; k++)
				vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pole_d[0] <= side_s2.pole;
			for (int k = 1; k < VL; k++)
				pole_d[k] <= pole_d[k-1];
		end
	end

	r2e_cordic #(.STAGES(CORDIC_STAGES)) u_bank (
		.clk   (clk),
		.adv   (adv),
		.y_in  (side_d[SQ_STAGES-1].bank_y),
		.x_in  (side_d[SQ_STAGES-1].bank_x),
		.angle (bank_a)
	);

	r2e_cordic #(.STAGES(CORDIC_STAGES)) u_asin (
		.clk   (clk),
		.adv   (adv),
		.y_in  (side_d[SQ_STAGES-1].asin_y),
		.x_in  (signed'(OPW'(root))),
		.angle (asin_a)
	);

	r2e_cordic #(.STAGES(CORDIC_STAGES)) u_head (
		.clk   (clk),
		.adv   (adv),
		.y_in  (side_d[SQ_STAGES-1].head_y),
		.x_in  (side_d[SQ_STAGES-1].head_x),
		.angle (head_a)
	);

	// Output register: at a pole, bank is zero and attitude is plus or minus half pi.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_d[VL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pole_q <= pole_d[VL-1];
			head_q <= head_a;
			case (pole_d[VL-1])
				POLE_NORTH: begin
					bank_q <= '0;
					att_q  <= HALF_PI_Q13[14:0];
				end
				POLE_SOUTH: begin
					bank_q <= '0;
					att_q  <= 15'(-HALF_PI_Q13);
				end
				default: begin
					bank_q <= bank_a;
					att_q  <= asin_a[14:0];
				end
			endcase
		end
	end

	assign ang.valid          = out_valid_q;
	assign ang.bank_angle     = bank_q;
	assign ang.attitude_angle = att_q;
	assign ang.heading_angle  = head_q;
	assign ang.pole_case      = pole_q;

	// A pole result always carries a zero bank angle.
	a_pole_bank: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid && (ang.pole_case != POLE_NONE) |-> ang.bank_angle == 16'sd0)
		else $error("pole result with nonzero bank");

	// Attitude never leaves plus or minus half pi.
	a_att_range: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid |-> (ang.attitude_angle <= 15'sd12868) && (ang.attitude_angle >= -15'sd12868))
		else $error("attitude out of range");

	// A waiting output beat freezes the whole pipeline, input included.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid && !ang.ready |-> !mat.ready)
		else $error("input accepted while the pipeline is frozen");

	// A configuration write lands in the threshold register.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |=> thr_q == $past(cfg.data))
		else $error("threshold write lost");
endmodule
`default_nettype wire

>>> hdl/r2e_isqrt.sv
// Pipelined integer floor square root, one root bit per register stage.
// Depends on r2e_pkg for the radicand, root and stage-count constants.
`default_nettype none
module r2e_isqrt (
	input  wire logic                       clk,
	input  wire logic                       adv,
	input  wire logic [r2e_pkg::SQ_NW-1:0]  radicand,
	output logic      [r2e_pkg::SQ_STAGES-1:0] root
);
	import r2e_pkg::*;

	logic [SQ_RW-1:0] n_s [0:SQ_STAGES];
	logic [SQ_RW-1:0] r_s [0:SQ_STAGES];

	assign n_s[0] = SQ_RW'(radicand);
	assign r_s[0] = '0;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		localparam logic [SQ_RW-1:0] BIT = SQ_RW'(1) << (2 * (SQ_STAGES - 1 - k));
		always_ff @(posedge clk) begin
			if (adv) begin
				if (n_s[k] >= r_s[k] + BIT) begin
					n_s[k+1] <= n_s[k] - (r_s[k] + BIT);
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1] <= n_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root = r_s[SQ_STAGES][SQ_STAGES-1:0];
endmodule
`default_nettype wire

>>> hdl/r2e_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in Q2.13, one rotation per stage.
// Depends on r2e_pkg for widths, the arctangent table and the pi constants.
`default_nettype none
module r2e_cordic #(
	parameter int STAGES = r2e_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         adv,
	input  wire logic signed [r2e_pkg::OPW-1:0] y_in,
	input  wire logic signed [r2e_pkg::OPW-1:0] x_in,
	output logic signed [15:0]                angle
);
	import r2e_pkg::*;

	localparam int NST = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

	logic signed [DW-1:0] x_s [0:NST];
	logic signed [DW-1:0] y_s [0:NST];
	logic signed [ZW-1:0] z_s [0:NST];
	logic                 zero_s [0:NST];
	logic signed [DW-1:0] xe, ye;
	logic signed [ZW-1:0] zr, zsh;

	assign xe = DW'(x_in);
	assign ye = DW'(y_in);

	// A vector in the left half plane is turned by pi before the rotations.
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				z_s[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
				x_s[0] <= (-xe) <<< 10;
				y_s[0] <= (-ye) <<< 10;
			end else begin
				z_s[0] <= '0;
				x_s[0] <= xe <<< 10;
				y_s[0] <= ye <<< 10;
			end
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ANG;
				end
			end
		end
	end

	// Round half up from Q.30 to Q2.13, then clamp to plus or minus pi.
	assign zr  = z_s[NST] + (ZW'(1) <<< 16);
	assign zsh = zr >>> 17;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s[NST])
				angle <= '0;
			else if (zsh > ZW'(PI_Q13))
				angle <= PI_Q13;
			else if (zsh < -ZW'(PI_Q13))
				angle <= -PI_Q13;
			else
				angle <= zsh[15:0];
		end
	end
endmodule
`default_nettype wire

>>> sim/rotation_to_euler_angles_unit_tb.sv
// Testbench of the rotation-to-Euler-angles unit: directed and random matrices are sent,
// and every angle beat is checked against an in-bench fixed-point CORDIC prediction.
// Depends on r2e_pkg, the channel interfaces and rotation_to_euler_angles_unit.
`default_nettype none
module rotation_to_euler_angles_unit_tb;
	import r2e_pkg::*;

	// A matrix beat as the driver offers it.
	typedef struct {
		logic signed [15:0] r00, r02, r10, r11, r12, r20, r22;
	} matrix_t;

	// The angles the unit should give for one matrix.
	typedef struct {
		logic signed [15:0] bank;
		logic signed [14:0] att;
		logic signed [15:0] head;
		pole_t              pole;
	} angles_t;

	localparam int STAGES    = 16;
	localparam int LATENCY   = 39;
	localparam int CYCLE_MAX = 400000;

	logic clk;
	logic arst_n;

	r2e_mat_if mat ();
	r2e_ang_if ang ();
	r2e_cfg_if cfg ();

	rotation_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.mat   (mat.sink),
		.ang   (ang.source),
		.cfg   (cfg.sink)
	);

	// Matrices waiting for the driver, and the angles waiting for the monitor.
	matrix_t matrix_q[$];
	angles_t angles_q[$];

	// The threshold the predictor uses; it follows each register write.
	logic [14:0] threshold;
	int          errors;
	int          cycles;
	bit          src_gaps;
	bit          sink_gaps;
	int          hold_off;
	bit          hold_req;

	// Arctangent table of the predictor, atan(2^-i) in Q.30.
	longint atan_q30 [0:23] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Vectoring CORDIC arctangent with rounding to Q2.13 and saturation to +/- pi.
	// SystemVerilog >>> on a longint is a floor shift, which is what the datapath does.
	function automatic longint cordic_angle(longint y, longint x);
		longint z;
		longint xs;
		longint ys;
		longint r;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		// A vector in the left half plane is turned by pi before rotating.
		if (x < 0) begin
			z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
			x = -x;
			y = -y;
		end
		x = x * 1024;
		y = y * 1024;
		for (int i = 0; i < ((STAGES > 24) ? 24 : STAGES); i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_q30[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_q30[i];
			end
		end
		r = (z + 64'sd65536) >>> 17;
		if (r > 25736)
			r = 25736;
		if (r < -25736)
			r = -25736;
		return r;
	endfunction

	// Arcsine as atan2(s, sqrt(1 - s*s)), the root taken as an exact floor root.
	function automatic longint arcsine(longint s);
		longint rad;
		longint root;
		if (s > 16384)
			s = 16384;
		if (s < -16384)
			s = -16384;
		rad = ((64'sd1 << 28) - s * s) << 8;
		root = 0;
		for (int b = 20; b >= 0; b--) begin
			if ((root + (64'sd1 << b)) * (root + (64'sd1 << b)) <= rad)
				root = root + (64'sd1 << b);
		end
		return cordic_angle(s * 16, root);
	endfunction

	function automatic angles_t euler_of(matrix_t m);
		angles_t a;
		longint  thr;
		thr = longint'(threshold);
		if (m.r10 > thr || m.r10 < -thr) begin
			// Gimbal lock: bank is zero and heading takes the whole rotation.
			a.bank = '0;
			a.att  = (m.r10 > thr) ? 15'sd12868 : -15'sd12868;
			a.head = 16'(cordic_angle(m.r02, m.r22));
			a.pole = (m.r10 > thr) ? POLE_NORTH : POLE_SOUTH;
		end else begin
			a.bank = 16'(cordic_angle(-longint'(m.r12), m.r11));
			a.att  = 15'(arcsine(m.r10));
			a.head = 16'(cordic_angle(-longint'(m.r20), m.r00));
			a.pole = POLE_NONE;
		end
		return a;
	endfunction

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom_range(0, 65535));  // Beyond unit range, all bits.
			3: return '0;
			default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
		endcase
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		m.r00 = rand_entry();
		m.r02 = rand_entry();
		m.r10 = rand_entry();
		m.r11 = rand_entry();
		m.r12 = rand_entry();
		m.r20 = rand_entry();
		m.r22 = rand_entry();
		// Aim r10 near the threshold now and then so both sides of the compare are hit.
		if ($urandom_range(0, 7) == 0)
			m.r10 = 16'(threshold) + 16'($urandom_range(0, 4)) - 16'sd2;
		else if ($urandom_range(0, 7) == 0)
			m.r10 = -16'(threshold) + 16'($urandom_range(0, 4)) - 16'sd2;
		return m;
	endfunction

	function automatic matrix_t mk(int a, int b, int c, int d, int e, int f, int g);
		matrix_t m;
		m.r00 = 16'(a);
		m.r02 = 16'(b);
		m.r10 = 16'(c);
		m.r11 = 16'(d);
		m.r12 = 16'(e);
		m.r20 = 16'(f);
		m.r22 = 16'(g);
		return m;
	endfunction

	// Appends one matrix to the driver's pending list.
	function automatic void add_matrix(matrix_t m);
		matrix_q = {matrix_q, m};
	endfunction

	// Driver: offers the oldest pending matrix; the prediction is made when the beat
	// is taken, so it uses the threshold in force at that moment.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat.valid <= 1'b0;
			mat.r00 <= '0;
			mat.r02 <= '0;
			mat.r10 <= '0;
			mat.r11 <= '0;
			mat.r12 <= '0;
			mat.r20 <= '0;
			mat.r22 <= '0;
		end else begin
			if (mat.valid && mat.ready) begin
				angles_q = {angles_q, euler_of(matrix_q.pop_front())};
			end
			if ((!mat.valid || mat.ready) && matrix_q.size() > 0 &&
					!(src_gaps && $urandom_range(0, 99) < 34)) begin
				mat.valid <= 1'b1;
				mat.r00 <= matrix_q[0].r00;
				mat.r02 <= matrix_q[0].r02;
				mat.r10 <= matrix_q[0].r10;
				mat.r11 <= matrix_q[0].r11;
				mat.r12 <= matrix_q[0].r12;
				mat.r20 <= matrix_q[0].r20;
				mat.r22 <= matrix_q[0].r22;
			end else if (mat.ready) begin
				mat.valid <= 1'b0;
			end
		end
	end

	// The long hold-off of the receiver is counted here, apart from the monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_off <= 0;
		else if (hold_req && hold_off == 0)
			hold_off <= 300;
		else if (hold_off > 1)
			hold_off <= hold_off - 1;
		else if (hold_off == 1 && !hold_req)
			hold_off <= 0;
	end

	// Monitor: takes angle beats and checks each field against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		angles_t exp_a;
		if (!arst_n) begin
			ang.ready <= 1'b0;
		end else begin
			if (ang.valid && ang.ready) begin
				if (angles_q.size() == 0) begin
					$display("%0t: angle beat with nothing expected", $time);
					errors++;
				end else begin
					exp_a = angles_q.pop_front();
					if (ang.bank_angle !== exp_a.bank) begin
						$display("%0t: bank expected %0d actual %0d", $time, exp_a.bank,
							ang.bank_angle);
						errors++;
					end
					if (ang.attitude_angle !== exp_a.att) begin
						$display("%0t: attitude expected %0d actual %0d", $time, exp_a.att,
							ang.attitude_angle);
						errors++;
					end
					if (ang.heading_angle !== exp_a.head) begin
						$display("%0t: heading expected %0d actual %0d", $time, exp_a.head,
							ang.heading_angle);
						errors++;
					end
					if (ang.pole_case !== exp_a.pole) begin
						$display("%0t: pole expected %0d actual %0d", $time, exp_a.pole,
							ang.pole_case);
						errors++;
					end
				end
			end
			ang.ready <= (hold_off > 1) ? 1'b0 :
				!(sink_gaps && $urandom_range(0, 99) < 34);
		end
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Waits until every sent matrix has been taken and every angle beat has come back,
	// then lets the pipeline drain a little more.
	task automatic drain();
		while (matrix_q.size() > 0 || mat.valid || angles_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Register write on the configuration channel; only called while the unit is idle.
	task automatic write_threshold(logic [14:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		threshold = value;
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			add_matrix(rand_matrix());
	endtask

	initial begin
		threshold = 15'd16351;
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		hold_req  = 1'b0;
		cfg.valid = 1'b0;
		cfg.data  = '0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, the extremes, both poles, zero operand pairs and
		// negative x operands with positive, zero and negative y.
		add_matrix(mk(16384, 0, 0, 16384, 0, 0, 16384));
		add_matrix(mk(0, 0, 0, 0, 0, 0, 0));
		add_matrix(mk(-16384, 0, 0, -16384, 0, 0, -16384));
		add_matrix(mk(-16384, 16384, 0, -16384, -16384, 16384, -16384));
		add_matrix(mk(-16384, 16384, 0, -16384, 16384, -16384, -16384));
		add_matrix(mk(0, 5000, 16384, 0, 0, 0, -3000));
		add_matrix(mk(0, -5000, -16384, 0, 0, 0, 3000));
		add_matrix(mk(100, 0, 16351, 200, 300, 400, 0));
		add_matrix(mk(100, 0, 16352, 200, 300, 400, 0));
		add_matrix(mk(100, 0, -16351, 200, 300, 400, 0));
		add_matrix(mk(100, 0, -16352, 200, 300, 400, 0));
		add_matrix(mk(32767, -32768, 0, 32767, -32768, 32767, -32768));
		add_matrix(mk(-32768, 32767, 32767, -32768, 32767, -32768, 32767));
		add_matrix(mk(-32768, 32767, -32768, -32768, 32767, -32768, 32767));
		add_matrix(mk(-1, -1, -1, -1, -1, -1, -1));
		add_matrix(mk(11585, 0, 11585, 11585, -11585, 11585, 11585));
		drain();

		// Threshold zero: every nonzero r10 is a pole; at the unit threshold an out-of-range r10 is a
		// pole, and under the largest threshold it is saturated before the arcsine.
		write_threshold(15'd0);
		add_matrix(mk(300, 200, 0, 300, 100, 50, 400));
		add_matrix(mk(300, 200, 1, 300, 100, 50, 400));
		add_matrix(mk(300, 200, -1, 300, 100, 50, 400));
		add_random(200);
		drain();
		write_threshold(15'd16384);
		add_matrix(mk(300, 200, 16384, 300, 100, 50, 400));
		add_matrix(mk(300, 200, 20000, 300, 100, 50, 400));
		add_matrix(mk(300, 200, -20000, 300, 100, 50, 400));
		add_random(300);
		drain();
		write_threshold(15'h7fff);
		add_random(100);
		drain();

		// Long stretch with no idling at all.
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		write_threshold(15'($urandom_range(0, 16384)));
		add_random(300);
		drain();

		// Receiver holds off while the sender keeps offering, so the unit backs up.
		write_threshold(15'd16351);
		add_random(200);
		hold_req = 1'b1;
		while (hold_off == 0)
			@(posedge clk);
		hold_req = 1'b0;
		drain();

		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		for (int p = 0; p < 4; p++) begin
			write_threshold(15'($urandom_range(16000, 16384)));
			add_random(100);
			drain();
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
